// ===== rtl/rqn_pkg.sv =====
package rqn_pkg;

  // Pixels in one 2x2 block, fixed by the port list.
  localparam int unsigned NumPixels = 4;

  // Width of a pixel component and of every result sample.
  localparam int unsigned SampleW = 8;

  // Numerators are the BT.601 sums scaled by 1000; they stay below 2^18.
  localparam int unsigned NumW = 18;

  // The chroma sum of four samples needs two more bits than one sample.
  localparam int unsigned SumW = SampleW + 2;

  // Coefficients scaled by 1000.
  localparam int unsigned YR = 257;
  localparam int unsigned YG = 504;
  localparam int unsigned YB = 98;
  localparam int unsigned YOff = 16000;
  localparam int unsigned UR = 148;
  localparam int unsigned UG = 291;
  localparam int unsigned UB = 439;
  localparam int unsigned VR = 439;
  localparam int unsigned VG = 368;
  localparam int unsigned VB = 71;
  localparam int unsigned COff = 128000;

  // x / 1000 is computed as (x >> 3) / 125, and the division by 125 as a
  // multiplication by ceil(2^22 / 125) and a shift by 22. With x >> 3 below
  // 2^15 the error term stays under one quotient step, so the result is exact.
  localparam int unsigned PreShift = 3;
  localparam int unsigned RecipShift = 22;
  localparam int unsigned Recip = 33555;
  localparam int unsigned RecipW = 16;
  localparam int unsigned DivInW = NumW - PreShift;
  localparam int unsigned ProdW = DivInW + RecipW;

  // Load enables for the two pipeline stages of a lane.
  typedef struct packed {
    logic ld_num;
    logic ld_quo;
  } rqn_lane_ctl_t;

  typedef logic [SampleW-1:0] sample_t;
  typedef logic [NumW-1:0]    num_t;

  // Exact floor(x / 1000) for the numerator range used here.
  function automatic sample_t div_1000(input num_t x);
    logic [DivInW-1:0] y;
    logic [ProdW-1:0]  prod;
    y    = x[NumW-1:PreShift];
    prod = ProdW'(y) * ProdW'(Recip);
    return prod[RecipShift +: SampleW];
  endfunction

endpackage

// ===== rtl/rqn_lane.sv =====
module rqn_lane
  import rqn_pkg::*;
(
  input  logic          clk_i,
  input  rqn_lane_ctl_t ctl_i,
  input  sample_t       red_i,
  input  sample_t       green_i,
  input  sample_t       blue_i,
  output sample_t       luma_o,
  output sample_t       cb_o,
  output sample_t       cr_o
);

  num_t    y_num_q, u_num_q, v_num_q;
  num_t    y_num_d, u_num_d, v_num_d;
  sample_t luma_q, cb_q, cr_q;

  // All three numerators are positive over the full input range, so plain
  // unsigned arithmetic in NumW bits never wraps.
  always_comb begin
    y_num_d = NumW'(YR) * NumW'(red_i) + NumW'(YG) * NumW'(green_i)
            + NumW'(YB) * NumW'(blue_i) + NumW'(YOff);
    u_num_d = NumW'(COff) + NumW'(UB) * NumW'(blue_i)
            - NumW'(UR) * NumW'(red_i) - NumW'(UG) * NumW'(green_i);
    v_num_d = NumW'(COff) + NumW'(VR) * NumW'(red_i)
            - NumW'(VG) * NumW'(green_i) - NumW'(VB) * NumW'(blue_i);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_num) begin
      y_num_q <= y_num_d;
      u_num_q <= u_num_d;
      v_num_q <= v_num_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_quo) begin
      luma_q <= div_1000(y_num_q);
      cb_q   <= div_1000(u_num_q);
      cr_q   <= div_1000(v_num_q);
    end
  end

  assign luma_o = luma_q;
  assign cb_o   = cb_q;
  assign cr_o   = cr_q;

endmodule

// ===== rtl/rqn_merge.sv =====
module rqn_merge
  import rqn_pkg::*;
(
  input  logic    clk_i,
  input  logic    ld_i,
  input  sample_t luma_i [NumPixels],
  input  sample_t cb_i   [NumPixels],
  input  sample_t cr_i   [NumPixels],
  output sample_t luma_o [NumPixels],
  output sample_t cb_o,
  output sample_t cr_o
);

  logic [SumW-1:0] cb_sum, cr_sum;
  sample_t         luma_q [NumPixels];
  sample_t         cb_q, cr_q;

  always_comb begin
    cb_sum = '0;
    cr_sum = '0;
    for (int p = 0; p < NumPixels; p++) begin
      cb_sum = cb_sum + SumW'(cb_i[p]);
      cr_sum = cr_sum + SumW'(cr_i[p]);
    end
  end

  // The mean of four is the sum shifted right by two.
  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      luma_q <= luma_i;
      cb_q   <= cb_sum[SumW-1:2];
      cr_q   <= cr_sum[SumW-1:2];
    end
  end

  assign luma_o = luma_q;
  assign cb_o   = cb_q;
  assign cr_o   = cr_q;

endmodule

// ===== rtl/rgb_quad_to_nv12.sv =====
// Channel  Direction  Handshake                Payload
// input    in         in_valid_i / in_stall_o  twelve 8-bit RGB components of a 2x2 block
// output   out        out_valid_o / out_stall_i four luma samples, one Cb, one Cr
//
// A request is accepted in every cycle that in_stall_o is low, so the block
// sustains one 2x2 block per clock while the output is not stalled. Stages: numerator sums,
// the division by 1000 in each lane, and the chroma merge into the output register.
// Reset clears only the stage valid bits; the data registers are not reset.
// A stall on the output fills the pipeline bubble by bubble before it reaches the input.
module rgb_quad_to_nv12
  import rqn_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  sample_t top_left_red_i,
  input  sample_t top_left_green_i,
  input  sample_t top_left_blue_i,
  input  sample_t top_right_red_i,
  input  sample_t top_right_green_i,
  input  sample_t top_right_blue_i,
  input  sample_t bottom_left_red_i,
  input  sample_t bottom_left_green_i,
  input  sample_t bottom_left_blue_i,
  input  sample_t bottom_right_red_i,
  input  sample_t bottom_right_green_i,
  input  sample_t bottom_right_blue_i,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output sample_t top_left_luma_o,
  output sample_t top_right_luma_o,
  output sample_t bottom_left_luma_o,
  output sample_t bottom_right_luma_o,
  output sample_t chroma_blue_diff_o,
  output sample_t chroma_red_diff_o
);

  // Gather the pixels in raster order so each lane handles one pixel.
  sample_t red   [NumPixels];
  sample_t green [NumPixels];
  sample_t blue  [NumPixels];

  assign red[0]   = top_left_red_i;
  assign green[0] = top_left_green_i;
  assign blue[0]  = top_left_blue_i;
  assign red[1]   = top_right_red_i;
  assign green[1] = top_right_green_i;
  assign blue[1]  = top_right_blue_i;
  assign red[2]   = bottom_left_red_i;
  assign green[2] = bottom_left_green_i;
  assign blue[2]  = bottom_left_blue_i;
  assign red[3]   = bottom_right_red_i;
  assign green[3] = bottom_right_green_i;
  assign blue[3]  = bottom_right_blue_i;

  // Stage valid bits: numerators, quotients, and the output register.
  logic num_vld_q, quo_vld_q, out_vld_q;
  logic num_vld_d, quo_vld_d, out_vld_d;

  // A stage can take a new request when it is empty or when its contents
  // move on in the same cycle. This lets a held result coexist with new
  // work in the earlier stages.
  logic out_rdy, quo_rdy, num_rdy;

  assign out_rdy = !out_vld_q || !out_stall_i;
  assign quo_rdy = !quo_vld_q || out_rdy;
  assign num_rdy = !num_vld_q || quo_rdy;

  assign num_vld_d = num_rdy ? in_valid_i : num_vld_q;
  assign quo_vld_d = quo_rdy ? num_vld_q  : quo_vld_q;
  assign out_vld_d = out_rdy ? quo_vld_q  : out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_vld_q <= 1'b0;
      quo_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      num_vld_q <= num_vld_d;
      quo_vld_q <= quo_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Data registers load only when a valid request actually enters them.
  rqn_lane_ctl_t lane_ctl;
  logic          out_ld;

  assign lane_ctl.ld_num = num_rdy && in_valid_i;
  assign lane_ctl.ld_quo = quo_rdy && num_vld_q;
  assign out_ld          = out_rdy && quo_vld_q;

  sample_t lane_luma [NumPixels];
  sample_t lane_cb   [NumPixels];
  sample_t lane_cr   [NumPixels];

  for (genvar p = 0; p < NumPixels; p++) begin : g_lane
    rqn_lane u_lane (
      .clk_i   (clk_i),
      .ctl_i   (lane_ctl),
      .red_i   (red[p]),
      .green_i (green[p]),
      .blue_i  (blue[p]),
      .luma_o  (lane_luma[p]),
      .cb_o    (lane_cb[p]),
      .cr_o    (lane_cr[p])
    );
  end

  // The merge stage averages the four chroma pairs and holds the result.
  sample_t out_luma [NumPixels];

  rqn_merge u_merge (
    .clk_i  (clk_i),
    .ld_i   (out_ld),
    .luma_i (lane_luma),
    .cb_i   (lane_cb),
    .cr_i   (lane_cr),
    .luma_o (out_luma),
    .cb_o   (chroma_blue_diff_o),
    .cr_o   (chroma_red_diff_o)
  );

  assign top_left_luma_o     = out_luma[0];
  assign top_right_luma_o    = out_luma[1];
  assign bottom_left_luma_o  = out_luma[2];
  assign bottom_right_luma_o = out_luma[3];

  assign in_stall_o  = !num_rdy;
  assign out_valid_o = out_vld_q;

endmodule

// ===== rtl/rqn_checker.sv =====
module rqn_checker
  import rqn_pkg::*;
(
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_valid_i,
  input logic    in_stall_o,
  input logic    out_valid_o,
  input logic    out_stall_i,
  input sample_t top_left_luma_o,
  input sample_t top_right_luma_o,
  input sample_t bottom_left_luma_o,
  input sample_t bottom_right_luma_o,
  input sample_t chroma_blue_diff_o,
  input sample_t chroma_red_diff_o
);

  // A stalled result stays offered.
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(top_left_luma_o) && $stable(top_right_luma_o) &&
      $stable(bottom_left_luma_o) && $stable(bottom_right_luma_o) &&
      $stable(chroma_blue_diff_o) && $stable(chroma_red_diff_o))
    else $error("stalled result changed");

  // When an accepted request could first reach the output register,
  // a result is on offer, its own or an earlier one held by a stall.
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> ##3 out_valid_o)
    else $error("accepted request did not reach the output");

  // Studio-swing luma stays in 16..235.
  a_luma_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      top_left_luma_o >= 8'd16 && top_left_luma_o <= 8'd235 &&
      top_right_luma_o >= 8'd16 && top_right_luma_o <= 8'd235 &&
      bottom_left_luma_o >= 8'd16 && bottom_left_luma_o <= 8'd235 &&
      bottom_right_luma_o >= 8'd16 && bottom_right_luma_o <= 8'd235)
    else $error("luma out of range");

  // Averaged chroma stays in 16..239.
  a_chroma_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      chroma_blue_diff_o >= 8'd16 && chroma_blue_diff_o <= 8'd239 &&
      chroma_red_diff_o >= 8'd16 && chroma_red_diff_o <= 8'd239)
    else $error("chroma out of range");

endmodule

bind rgb_quad_to_nv12 rqn_checker u_rqn_checker (.*);
